[hw/rtl/kfmj_pkg.sv]
// Shared types and constants for the key FIFO, mouse and joystick input block.
// Holds the request and result structs, action and status codes, and FIFO sizing.
// No dependencies; every other file of the block imports this package.
package kfmj_pkg;

  // FIFO sizing. The index and count widths follow from the depth.
  localparam int KEY_FIFO_DEPTH = 16;
  localparam int KEY_IDX_W      = (KEY_FIFO_DEPTH > 1) ? $clog2(KEY_FIFO_DEPTH) : 1;
  localparam int KEY_CNT_W      = $clog2(KEY_FIFO_DEPTH + 1);

  // Number of player ports.
  localparam int NUM_PORTS = 2;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_JOY   = 2'd2,
    ACT_MOUSE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_BADPORT = 2'd3
  } status_t;

  // One request item.
  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         port;
    logic [7:0]         data_byte;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [7:0]         button_bits;
  } kfmj_req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         popped_key;
    logic [7:0]         key_data;
    logic               key_ready;
    logic [7:0]         joy_value;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic [7:0]         mouse_buttons;
  } kfmj_rsp_t;

  // Commands from the top level into the key FIFO.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } kfmj_fifo_cmd_t;

  // FIFO status now, and its register view after the commanded update.
  typedef struct packed {
    logic       full;
    logic       empty;
    logic [7:0] popped_key;
    logic [7:0] key_data;
    logic       key_ready;
  } kfmj_fifo_view_t;

endpackage

[hw/rtl/kfmj_key_fifo.sv]
// Keyboard scancode FIFO: flip-flop storage, head and tail pointers, fill count.
// Keeps the head entry in its own register so each result needs one array read.
// Depends on kfmj_pkg.
module kfmj_key_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  kfmj_pkg::kfmj_fifo_cmd_t cmd,
  output kfmj_pkg::kfmj_fifo_view_t view
);
  import kfmj_pkg::*;

  logic [7:0]           store [KEY_FIFO_DEPTH];
  logic [KEY_IDX_W-1:0] head;
  logic [KEY_IDX_W-1:0] tail;
  logic [KEY_CNT_W-1:0] count;
  logic [7:0]           head_key;

  logic [KEY_IDX_W-1:0] head_next;
  logic [KEY_IDX_W-1:0] tail_next;
  logic [KEY_CNT_W-1:0] count_next;
  logic [7:0]           head_key_next;
  logic [KEY_IDX_W-1:0] head_adv;
  logic [KEY_IDX_W-1:0] tail_adv;

  // Pointer advance with wrap at the FIFO depth.
  assign head_adv = (head == KEY_IDX_W'(KEY_FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_adv = (tail == KEY_IDX_W'(KEY_FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;

  // Next pointer, count and head entry values.
  always_comb begin
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    head_key_next = head_key;
    if (cmd.push) begin
      tail_next  = tail_adv;
      count_next = count + 1'b1;
      // A key pushed into an empty FIFO becomes the head at once.
      if (count == '0) begin
        head_key_next = cmd.data;
      end
    end else if (cmd.pop) begin
      head_next  = head_adv;
      count_next = count - 1'b1;
      // The entry behind the head moves up; it holds a key only if one remains.
      head_key_next = (count > KEY_CNT_W'(1)) ? store[head_adv] : 8'd0;
    end
  end

  // Status now and view after the update.
  always_comb begin
    view.full       = (count == KEY_CNT_W'(KEY_FIFO_DEPTH));
    view.empty      = (count == '0);
    view.popped_key = cmd.pop ? head_key : 8'd0;
    view.key_ready  = (count_next != '0);
    view.key_data   = (count_next != '0) ? head_key_next : 8'd0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Storage and head entry; their contents only matter once written.
  always_ff @(posedge clk) begin
    head_key <= head_key_next;
    if (cmd.push) begin
      store[tail] <= cmd.data;
    end
  end

  // The fill count never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= KEY_CNT_W'(KEY_FIFO_DEPTH))
    else $error("key FIFO count above depth");

  // The top level never pushes and pops in the same cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("key FIFO push and pop together");

  // A push lands in a FIFO that has room and grows the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !view.full ##1 count == $past(count) + 1'b1)
    else $error("key FIFO push count mismatch");

  // A pop takes from a FIFO that holds a key and shrinks the count by one.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !view.empty ##1 count == $past(count) - 1'b1)
    else $error("key FIFO pop count mismatch");

  // An empty FIFO has its pointers together.
  a_empty_ptr: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("key FIFO empty with pointers apart");

endmodule

[hw/rtl/key_fifo_mouse_joystick_input.sv]
// Keyboard FIFO, joystick and mouse input block: top level.
// Request and result channels, port registers and the result register.
// Depends on kfmj_pkg and kfmj_key_fifo.
//
// Use:
//   A request (req, qualified by req_valid) carries one action: push a
//   scancode, pop a scancode, set a joystick byte, or move a mouse. It is
//   taken at a rising edge where req_valid is high and req_stall is low.
//   Each request yields exactly one result on rsp, qualified by rsp_valid
//   and taken when rsp_stall is low: a status code and the register view
//   after the action (FIFO head, key-ready flag, and the joystick and
//   mouse values of the requested port, zero for a port above 1).
// Timing:
//   The whole action is done in one pass from the request to the result
//   register, so the result appears in the cycle after acceptance and one
//   request is taken every cycle while the result side keeps up.
//   req_stall rises only while a result is held under rsp_stall; the held
//   result stays unchanged until it is taken.
// Reset (rst, synchronous, active high) empties the FIFO, clears all port
// state and drops rsp_valid.
module key_fifo_mouse_joystick_input (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  kfmj_pkg::kfmj_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output kfmj_pkg::kfmj_rsp_t rsp
);
  import kfmj_pkg::*;

  logic [7:0]  joy     [NUM_PORTS];
  logic [15:0] pos_x   [NUM_PORTS];
  logic [15:0] pos_y   [NUM_PORTS];
  logic [7:0]  buttons [NUM_PORTS];

  logic            accept;
  logic            port_ok;
  logic            sel;
  logic            joy_we;
  logic            mouse_we;
  logic [15:0]     pos_x_sum;
  logic [15:0]     pos_y_sum;
  kfmj_fifo_cmd_t  fifo_cmd;
  kfmj_fifo_view_t fifo_view;
  kfmj_rsp_t       rsp_next;

  // Handshake: take a request unless a result is held back.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Port decode; only ports 0 and 1 exist.
  assign port_ok = !req.port[1];
  assign sel     = req.port[0];

  // Key FIFO commands; a refused push or pop changes nothing.
  always_comb begin
    fifo_cmd.push = accept && (req.action == ACT_PUSH) && !fifo_view.full;
    fifo_cmd.pop  = accept && (req.action == ACT_POP) && !fifo_view.empty;
    fifo_cmd.data = req.data_byte;
  end

  kfmj_key_fifo u_key_fifo (
    .clk  (clk),
    .rst  (rst),
    .cmd  (fifo_cmd),
    .view (fifo_view)
  );

  // Port register updates and wrapped mouse sums.
  assign joy_we    = accept && (req.action == ACT_JOY) && port_ok;
  assign mouse_we  = accept && (req.action == ACT_MOUSE) && port_ok;
  assign pos_x_sum = pos_x[sel] + req.delta_x;
  assign pos_y_sum = pos_y[sel] + req.delta_y;

  // Result: status and the view after this request.
  always_comb begin
    rsp_next = '0;
    case (req.action)
      ACT_PUSH:  rsp_next.status = fifo_view.full  ? STAT_FULL  : STAT_DONE;
      ACT_POP:   rsp_next.status = fifo_view.empty ? STAT_EMPTY : STAT_DONE;
      ACT_JOY:   rsp_next.status = port_ok ? STAT_DONE : STAT_BADPORT;
      ACT_MOUSE: rsp_next.status = port_ok ? STAT_DONE : STAT_BADPORT;
      default:   rsp_next.status = STAT_DONE;
    endcase
    rsp_next.popped_key = fifo_view.popped_key;
    rsp_next.key_data   = fifo_view.key_data;
    rsp_next.key_ready  = fifo_view.key_ready;
    if (port_ok) begin
      rsp_next.joy_value     = (req.action == ACT_JOY) ? req.data_byte : joy[sel];
      rsp_next.mouse_x       = (req.action == ACT_MOUSE) ? pos_x_sum : pos_x[sel];
      rsp_next.mouse_y       = (req.action == ACT_MOUSE) ? pos_y_sum : pos_y[sel];
      rsp_next.mouse_buttons = (req.action == ACT_MOUSE) ? req.button_bits
                                                         : buttons[sel];
    end
  end

  // Port state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        joy[i]     <= '0;
        pos_x[i]   <= '0;
        pos_y[i]   <= '0;
        buttons[i] <= '0;
      end
    end else begin
      if (joy_we) begin
        joy[sel] <= req.data_byte;
      end
      if (mouse_we) begin
        pos_x[sel]   <= pos_x_sum;
        pos_y[sel]   <= pos_y_sum;
        buttons[sel] <= req.button_bits;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result payload, loaded only when a request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Every accepted request shows up as a result in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request gave no result");

  // A held result is not overwritten.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("held result changed");

  // A bad port never alters the port registers.
  a_badport_keep: assert property (@(posedge clk) disable iff (rst)
    accept && !port_ok |=> $stable(joy[0]) && $stable(joy[1])
                           && $stable(pos_x[0]) && $stable(pos_x[1]))
    else $error("bad port changed port state");

endmodule

[tb/tb_key_fifo_mouse_joystick_input.sv]
// Testbench for key_fifo_mouse_joystick_input: directed table, then ~850 random requests.
// Every result is checked against a built-in model of the key FIFO and the port registers.
// Depends on kfmj_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_key_fifo_mouse_joystick_input;
  import kfmj_pkg::*;

  localparam int RANDOM_REQUESTS = 850;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_AT_RESULT  = 200;
  localparam int HOLD_CYCLES     = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  kfmj_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  kfmj_rsp_t rsp;

  key_fifo_mouse_joystick_input dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Model state: key FIFO and per-port joystick and mouse registers.
  logic [7:0]  key_mem [KEY_FIFO_DEPTH];
  int          rd_ptr = 0;
  int          wr_ptr = 0;
  int          fifo_fill = 0;
  logic [7:0]  joy_reg [NUM_PORTS] = '{default: '0};
  logic [15:0] pos_x [NUM_PORTS] = '{default: '0};
  logic [15:0] pos_y [NUM_PORTS] = '{default: '0};
  logic [7:0]  btn_reg [NUM_PORTS] = '{default: '0};

  kfmj_rsp_t pending_views [$];
  int        mismatches = 0;
  int        results_taken = 0;
  int        cycle_count = 0;
  bit        steady = 1'b0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  // One row of the directed table; reps repeats the row with data_byte counting up.
  typedef struct {
    kfmj_req_t r;
    int        reps;
    bit        typed;
    kfmj_rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic kfmj_rsp_t make_view(status_t st, logic [7:0] popped, logic [7:0] head,
                                          logic ready, logic [7:0] joy, logic [15:0] x,
                                          logic [15:0] y, logic [7:0] b);
    kfmj_rsp_t v;
    v.status        = st;
    v.popped_key    = popped;
    v.key_data      = head;
    v.key_ready     = ready;
    v.joy_value     = joy;
    v.mouse_x       = x;
    v.mouse_y       = y;
    v.mouse_buttons = b;
    return v;
  endfunction

  task automatic add_row(action_t act, logic [1:0] port, logic [7:0] data, logic [15:0] dx,
                         logic [15:0] dy, logic [7:0] b, int reps, bit typed, kfmj_rsp_t want);
    dir_row_t row;
    row.r.action      = act;
    row.r.port        = port;
    row.r.data_byte   = data;
    row.r.delta_x     = dx;
    row.r.delta_y     = dy;
    row.r.button_bits = b;
    row.reps          = reps;
    row.typed         = typed;
    row.want          = want;
    dir_rows.push_back(row);
  endtask

  // Apply one request to the model and return the register view after it.
  task automatic predict_view(input kfmj_req_t r, output kfmj_rsp_t v);
    logic       port_ok;
    logic       p;
    status_t    st;
    logic [7:0] popped;
    port_ok = (r.port <= 2'd1);
    p       = r.port[0];
    st      = STAT_DONE;
    popped  = '0;
    case (action_t'(r.action))
      ACT_PUSH: begin
        if (fifo_fill == KEY_FIFO_DEPTH) begin
          st = STAT_FULL;
        end else begin
          key_mem[wr_ptr] = r.data_byte;
          wr_ptr    = (wr_ptr + 1) % KEY_FIFO_DEPTH;
          fifo_fill = fifo_fill + 1;
        end
      end
      ACT_POP: begin
        if (fifo_fill == 0) begin
          st = STAT_EMPTY;
        end else begin
          popped    = key_mem[rd_ptr];
          rd_ptr    = (rd_ptr + 1) % KEY_FIFO_DEPTH;
          fifo_fill = fifo_fill - 1;
        end
      end
      ACT_JOY: begin
        if (!port_ok) begin
          st = STAT_BADPORT;
        end else begin
          joy_reg[p] = r.data_byte;
        end
      end
      default: begin
        if (!port_ok) begin
          st = STAT_BADPORT;
        end else begin
          pos_x[p]   = pos_x[p] + r.delta_x;
          pos_y[p]   = pos_y[p] + r.delta_y;
          btn_reg[p] = r.button_bits;
        end
      end
    endcase
    v = make_view(st, popped, (fifo_fill != 0) ? key_mem[rd_ptr] : 8'h00, fifo_fill != 0,
                  8'h00, 16'h0000, 16'h0000, 8'h00);
    if (port_ok) begin
      v.joy_value     = joy_reg[p];
      v.mouse_x       = pos_x[p];
      v.mouse_y       = pos_y[p];
      v.mouse_buttons = btn_reg[p];
    end
  endtask

  // Offer one request, wait for it to be taken, then queue the expected view.
  // Entered and left at a rising edge.
  task automatic send_request(input kfmj_req_t r, input bit typed, input kfmj_rsp_t want);
    kfmj_rsp_t v;
    if (!steady && $urandom_range(99) < 33) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predict_view(r, v);
    pending_views.push_back(typed ? want : v);
  endtask

  // Random request; mode leans the action mix toward filling, draining or mixing.
  function automatic kfmj_req_t rand_request(int mode);
    kfmj_req_t r;
    int        pick;
    int        ext;
    pick = $urandom_range(99);
    case (mode)
      0:       r.action = (pick < 60) ? ACT_PUSH : (pick < 75) ? ACT_POP :
                          (pick < 85) ? ACT_JOY : ACT_MOUSE;
      1:       r.action = (pick < 60) ? ACT_POP : (pick < 75) ? ACT_PUSH :
                          (pick < 85) ? ACT_JOY : ACT_MOUSE;
      default: r.action = 2'($urandom_range(3));
    endcase
    r.port        = ($urandom_range(99) < 85) ? 2'($urandom_range(1)) : 2'($urandom_range(2, 3));
    r.data_byte   = 8'($urandom);
    r.delta_x     = 16'($urandom);
    r.delta_y     = 16'($urandom);
    r.button_bits = 8'($urandom);
    // Now and then push the deltas to their extremes to exercise the wrap.
    if ($urandom_range(9) == 0) begin
      ext = $urandom_range(3);
      r.delta_x = (ext == 0) ? 16'h8000 : (ext == 1) ? 16'h7FFF : (ext == 2) ? 16'h0 : 16'hFFFF;
      ext = $urandom_range(3);
      r.delta_y = (ext == 0) ? 16'h8000 : (ext == 1) ? 16'h7FFF : (ext == 2) ? 16'h0 : 16'hFFFF;
    end
    return r;
  endfunction

  // Compare one taken result with the oldest expected view.
  task automatic check_result(input kfmj_rsp_t got);
    kfmj_rsp_t want;
    if (pending_views.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result with no request outstanding: %p", got);
      end
      return;
    end
    want = pending_views.pop_front();
    if (got.status !== want.status || got.popped_key !== want.popped_key ||
        got.key_data !== want.key_data || got.key_ready !== want.key_ready ||
        got.joy_value !== want.joy_value || got.mouse_x !== want.mouse_x ||
        got.mouse_y !== want.mouse_y || got.mouse_buttons !== want.mouse_buttons) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result %0d mismatch", results_taken);
        $display("  expected st=%0d pop=%h head=%h rdy=%b joy=%h x=%h y=%h btn=%h",
                 want.status, want.popped_key, want.key_data, want.key_ready,
                 want.joy_value, want.mouse_x, want.mouse_y, want.mouse_buttons);
        $display("  actual   st=%0d pop=%h head=%h rdy=%b joy=%h x=%h y=%h btn=%h",
                 got.status, got.popped_key, got.key_data, got.key_ready,
                 got.joy_value, got.mouse_x, got.mouse_y, got.mouse_buttons);
      end
    end
  endtask

  // Result side: take results, stall at random, and hold off once for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        check_result(rsp);
        results_taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && results_taken >= HOLD_AT_RESULT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        rsp_stall <= 1'b1;
      end else if (steady) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 33);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_key_fifo_mouse_joystick_input failed");
      $finish;
    end
  end

  // Request side: reset, directed table, then random requests in phases.
  initial begin
    kfmj_req_t r;
    int        mode;
    for (int i = 0; i < KEY_FIFO_DEPTH; i++) begin
      key_mem[i] = '0;
    end

    // Empty pop after reset, mouse wrap at both extremes, bad ports on every action,
    // a bad port on push and pop, a full FIFO, and a few pops out of the full FIFO.
    add_row(ACT_POP, 2'd0, 8'h00, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_EMPTY, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00));
    add_row(ACT_MOUSE, 2'd0, 8'h00, 16'h7FFF, 16'h8000, 8'hFF, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b0, 8'h00, 16'h7FFF, 16'h8000, 8'hFF));
    add_row(ACT_MOUSE, 2'd0, 8'h00, 16'h0001, 16'hFFFF, 8'h00, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b0, 8'h00, 16'h8000, 16'h7FFF, 8'h00));
    add_row(ACT_JOY, 2'd1, 8'hFF, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b0, 8'hFF, 16'h0000, 16'h0000, 8'h00));
    add_row(ACT_JOY, 2'd2, 8'hAA, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_BADPORT, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00));
    add_row(ACT_MOUSE, 2'd3, 8'h00, 16'h0064, 16'h0064, 8'h11, 1, 1'b1,
            make_view(STAT_BADPORT, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00));
    add_row(ACT_JOY, 2'd0, 8'h00, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b0, 8'h00, 16'h8000, 16'h7FFF, 8'h00));
    add_row(ACT_MOUSE, 2'd1, 8'h00, 16'hFFFF, 16'hFFFF, 8'h5A, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h5A));
    add_row(ACT_PUSH, 2'd3, 8'h00, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b1, 8'h00, 16'h0000, 16'h0000, 8'h00));
    add_row(ACT_POP, 2'd2, 8'h00, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_DONE, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00));
    add_row(ACT_PUSH, 2'd0, 8'h80, 16'h0000, 16'h0000, 8'h00, KEY_FIFO_DEPTH, 1'b0, '0);
    add_row(ACT_PUSH, 2'd1, 8'h55, 16'h0000, 16'h0000, 8'h00, 1, 1'b1,
            make_view(STAT_FULL, 8'h00, 8'h80, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h5A));
    add_row(ACT_POP, 2'd1, 8'h00, 16'h0000, 16'h0000, 8'h00, 3, 1'b0, '0);
    add_row(ACT_MOUSE, 2'd0, 8'h00, 16'h8000, 16'h8000, 8'h00, 1, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        r = dir_rows[i].r;
        r.data_byte = r.data_byte + 8'(k);
        send_request(r, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases of 50 requests; one stretch runs with no idling on either side.
    mode = 2;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 50 == 0) begin
        mode = $urandom_range(2);
      end
      steady = (n >= 400 && n < 550);
      send_request(rand_request(mode), 1'b0, '0);
    end
    steady    = 1'b0;
    req_valid <= 1'b0;

    // Drain what is still outstanding, then wait a little longer for stray results.
    while (pending_views.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_key_fifo_mouse_joystick_input passed");
    end else begin
      $display("tb_key_fifo_mouse_joystick_input failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/kfmj_pkg.sv
hw/rtl/kfmj_key_fifo.sv
hw/rtl/key_fifo_mouse_joystick_input.sv
tb/tb_key_fifo_mouse_joystick_input.sv
